@@ sv/gfa_pkg.sv @@
// Shared types, codes and widths of the GF(2^8) field arithmetic unit.
package gfa_pkg;

  localparam int FIELD_BITS = 8;
  localparam int ELEM_W = FIELD_BITS;
  localparam int POLY_W = FIELD_BITS + 1;
  localparam int DEG_W = $clog2(POLY_W);
  localparam int CNT_W = $clog2(POLY_W + 1);

  localparam logic [POLY_W-1:0] POLY_RESET = POLY_W'(12'h11b);

  localparam logic [CNT_W-1:0] ELEM_STEPS = CNT_W'(ELEM_W);
  localparam logic [CNT_W-1:0] POLY_STEPS = CNT_W'(POLY_W);

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_MUL = 3'd1;
  localparam logic [2:0] CMD_QUO = 3'd2;
  localparam logic [2:0] CMD_REM = 3'd3;
  localparam logic [2:0] CMD_INV = 3'd4;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_DIV0 = 2'd1;
  localparam logic [1:0] STAT_NOINV = 2'd2;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [ELEM_W-1:0] operand_a;
    logic [ELEM_W-1:0] operand_b;
  } gfa_req_t;

  typedef struct packed {
    logic [ELEM_W-1:0] result;
    logic [1:0]        status;
  } gfa_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MRED,
    ST_MMUL,
    ST_IDIV,
    ST_IMUL
  } gfa_state_t;

endpackage

@@ sv/gf2_8_field_alu_unit.sv @@
// Top level of the GF(2^8) field arithmetic unit with its bit-serial shared datapath.
//
// A command transfers on a rising edge with start high and busy low; its single
// result appears on res for exactly one cycle with done high, and the receiver
// cannot stall it. Add, the unused command codes, quotient or remainder by zero and
// the inverse of zero or one answer in the cycle after the transfer. Other quotient
// and remainder commands run one division; multiply first reduces operand_a by the
// field polynomial, then does the interleaved multiply; and each answers in the
// cycle after the last busy cycle. Inverse runs Euclid rounds, each one polynomial
// division followed by the Bezout multiply, at most 7 rounds. Quotient, remainder,
// multiply and inverse use the one shift-and-reduce step unit, which handles one
// bit per cycle. A new command may transfer in the same cycle as done. field_poly
// is written with cfg_we and cfg_data; the user must write it only while the unit
// is not busy, and the unit itself does not enforce this.
module gf2_8_field_alu_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  gfa_pkg::gfa_req_t               op,
  output logic                            done,
  output gfa_pkg::gfa_rsp_t               res,
  input  logic                            cfg_we,
  input  logic [gfa_pkg::POLY_W-1:0]      cfg_data
);

  gfa_pkg::gfa_state_t state, state_next;

  logic [gfa_pkg::POLY_W-1:0] field_poly;
  logic [gfa_pkg::CNT_W-1:0]  count, count_next;
  logic [2:0]                 opcode, opcode_next;
  logic [gfa_pkg::ELEM_W-1:0] opb, opb_next;
  logic [gfa_pkg::POLY_W-1:0] rem, rem_next;
  logic [gfa_pkg::POLY_W-1:0] sreg, sreg_next;
  logic [gfa_pkg::ELEM_W-1:0] quo, quo_next;
  logic [gfa_pkg::ELEM_W-1:0] x, x_next;
  logic [gfa_pkg::POLY_W-1:0] r2, r2_next;
  logic [gfa_pkg::POLY_W-1:0] r1, r1_next;
  logic [gfa_pkg::ELEM_W-1:0] b2, b2_next;
  logic [gfa_pkg::ELEM_W-1:0] b1, b1_next;
  gfa_pkg::gfa_rsp_t          res_next;
  logic                       done_next;

  logic [gfa_pkg::POLY_W-1:0] modulus;
  logic                       in_bit;
  logic [gfa_pkg::ELEM_W-1:0] addend;
  logic [gfa_pkg::DEG_W-1:0]  dm;
  logic                       m_nz;
  logic [gfa_pkg::POLY_W-1:0] shifted;
  logic                       hit;
  logic [gfa_pkg::POLY_W-1:0] rem_step;
  logic [gfa_pkg::ELEM_W-1:0] quo_step;
  logic [gfa_pkg::ELEM_W-1:0] nb;
  logic                       last;

  function automatic logic [gfa_pkg::DEG_W-1:0] degree(input logic [gfa_pkg::POLY_W-1:0] m);
    logic [gfa_pkg::DEG_W-1:0] d;
    d = '0;
    for (int i = 0; i < gfa_pkg::POLY_W; i++) begin
      if (m[i]) begin
        d = gfa_pkg::DEG_W'(i);
      end
    end
    return d;
  endfunction

  // The shared step unit: shift one bit in, reduce once, add an operand.
  always_comb begin
    modulus = field_poly;
    in_bit = 1'b0;
    addend = '0;
    case (state)
      gfa_pkg::ST_DIV: begin
        modulus = {1'b0, opb};
        in_bit = sreg[gfa_pkg::POLY_W-1];
      end
      gfa_pkg::ST_MRED: begin
        in_bit = sreg[gfa_pkg::POLY_W-1];
      end
      gfa_pkg::ST_IDIV: begin
        modulus = r1;
        in_bit = sreg[gfa_pkg::POLY_W-1];
      end
      gfa_pkg::ST_MMUL, gfa_pkg::ST_IMUL: begin
        addend = sreg[gfa_pkg::POLY_W-1] ? x : '0;
      end
      default: begin
        modulus = field_poly;
      end
    endcase
  end

  assign dm = degree(modulus);
  assign m_nz = |modulus;
  assign shifted = {rem[gfa_pkg::ELEM_W-1:0], in_bit};
  assign hit = m_nz && shifted[dm];
  assign rem_step = (hit ? (shifted ^ modulus) : shifted) ^ {1'b0, addend};
  assign quo_step = {quo[gfa_pkg::ELEM_W-2:0], hit};
  assign nb = b2 ^ rem_step[gfa_pkg::ELEM_W-1:0];
  assign last = (count == gfa_pkg::CNT_W'(1));
  assign busy = (state != gfa_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    opcode_next = opcode;
    opb_next = opb;
    rem_next = rem;
    sreg_next = sreg;
    quo_next = quo;
    x_next = x;
    r2_next = r2;
    r1_next = r1;
    b2_next = b2;
    b1_next = b1;
    res_next = res;
    done_next = 1'b0;
    case (state)
      gfa_pkg::ST_IDLE: begin
        if (start) begin
          opcode_next = op.cmd;
          opb_next = op.operand_b;
          rem_next = '0;
          quo_next = '0;
          sreg_next = {op.operand_a, 1'b0};
          count_next = gfa_pkg::ELEM_STEPS;
          res_next.result = '0;
          res_next.status = gfa_pkg::STAT_OK;
          case (op.cmd)
            gfa_pkg::CMD_ADD: begin
              res_next.result = op.operand_a ^ op.operand_b;
              done_next = 1'b1;
            end
            gfa_pkg::CMD_MUL: begin
              state_next = gfa_pkg::ST_MRED;
            end
            gfa_pkg::CMD_QUO: begin
              if (op.operand_b == '0) begin
                res_next.status = gfa_pkg::STAT_DIV0;
                done_next = 1'b1;
              end else begin
                state_next = gfa_pkg::ST_DIV;
              end
            end
            gfa_pkg::CMD_REM: begin
              if (op.operand_b == '0) begin
                res_next.result = op.operand_a;
                done_next = 1'b1;
              end else begin
                state_next = gfa_pkg::ST_DIV;
              end
            end
            gfa_pkg::CMD_INV: begin
              if (op.operand_b == gfa_pkg::ELEM_W'(1)) begin
                res_next.result = gfa_pkg::ELEM_W'(1);
                done_next = 1'b1;
              end else if (op.operand_b == '0) begin
                res_next.status = gfa_pkg::STAT_NOINV;
                done_next = 1'b1;
              end else begin
                r2_next = field_poly;
                r1_next = {1'b0, op.operand_b};
                b2_next = '0;
                b1_next = gfa_pkg::ELEM_W'(1);
                sreg_next = field_poly;
                count_next = gfa_pkg::POLY_STEPS;
                state_next = gfa_pkg::ST_IDIV;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      gfa_pkg::ST_DIV: begin
        rem_next = rem_step;
        quo_next = quo_step;
        sreg_next = {sreg[gfa_pkg::POLY_W-2:0], 1'b0};
        count_next = count - gfa_pkg::CNT_W'(1);
        if (last) begin
          res_next.result = (opcode == gfa_pkg::CMD_QUO) ? quo_step
                                                         : rem_step[gfa_pkg::ELEM_W-1:0];
          res_next.status = gfa_pkg::STAT_OK;
          done_next = 1'b1;
          state_next = gfa_pkg::ST_IDLE;
        end
      end
      gfa_pkg::ST_MRED: begin
        rem_next = rem_step;
        sreg_next = {sreg[gfa_pkg::POLY_W-2:0], 1'b0};
        count_next = count - gfa_pkg::CNT_W'(1);
        if (last) begin
          x_next = rem_step[gfa_pkg::ELEM_W-1:0];
          rem_next = '0;
          sreg_next = {opb, 1'b0};
          count_next = gfa_pkg::ELEM_STEPS;
          state_next = gfa_pkg::ST_MMUL;
        end
      end
      gfa_pkg::ST_MMUL: begin
        rem_next = rem_step;
        sreg_next = {sreg[gfa_pkg::POLY_W-2:0], 1'b0};
        count_next = count - gfa_pkg::CNT_W'(1);
        if (last) begin
          res_next.result = rem_step[gfa_pkg::ELEM_W-1:0];
          res_next.status = gfa_pkg::STAT_OK;
          done_next = 1'b1;
          state_next = gfa_pkg::ST_IDLE;
        end
      end
      gfa_pkg::ST_IDIV: begin
        rem_next = rem_step;
        quo_next = quo_step;
        sreg_next = {sreg[gfa_pkg::POLY_W-2:0], 1'b0};
        count_next = count - gfa_pkg::CNT_W'(1);
        if (last) begin
          r2_next = r1;
          r1_next = rem_step;
          x_next = b1;
          rem_next = '0;
          sreg_next = {quo_step, 1'b0};
          count_next = gfa_pkg::ELEM_STEPS;
          state_next = gfa_pkg::ST_IMUL;
        end
      end
      gfa_pkg::ST_IMUL: begin
        rem_next = rem_step;
        sreg_next = {sreg[gfa_pkg::POLY_W-2:0], 1'b0};
        count_next = count - gfa_pkg::CNT_W'(1);
        if (last) begin
          b2_next = b1;
          b1_next = nb;
          if (r1[gfa_pkg::POLY_W-1:1] != '0) begin
            rem_next = '0;
            quo_next = '0;
            sreg_next = r2;
            count_next = gfa_pkg::POLY_STEPS;
            state_next = gfa_pkg::ST_IDIV;
          end else if (r1[0]) begin
            res_next.result = nb;
            res_next.status = gfa_pkg::STAT_OK;
            done_next = 1'b1;
            state_next = gfa_pkg::ST_IDLE;
          end else begin
            res_next.result = r2[gfa_pkg::ELEM_W-1:0];
            res_next.status = gfa_pkg::STAT_NOINV;
            done_next = 1'b1;
            state_next = gfa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = gfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfa_pkg::ST_IDLE;
      done <= 1'b0;
      field_poly <= gfa_pkg::POLY_RESET;
    end else begin
      state <= state_next;
      done <= done_next;
      if (cfg_we) begin
        field_poly <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    count <= count_next;
    opcode <= opcode_next;
    opb <= opb_next;
    rem <= rem_next;
    sreg <= sreg_next;
    quo <= quo_next;
    x <= x_next;
    r2 <= r2_next;
    r1 <= r1_next;
    b2 <= b2_next;
    b1 <= b1_next;
    res <= res_next;
  end

`ifndef NO_ASSERTIONS
  // A result follows only a transfer or a busy cycle.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start || busy))
    else $error("result strobe without a command");

  // No result is shown while a command is still being worked on.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe while busy");

  // The step counter never runs out while the sequencer is active.
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != '0))
    else $error("step counter empty while busy");

  // Euclid divisions always use a divisor of degree one or more.
  a_idiv_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == gfa_pkg::ST_IDIV) |-> (r1[gfa_pkg::POLY_W-1:1] != '0))
    else $error("Euclid division by a constant");
`endif

endmodule
